[rtl/core/uapq_pkg.sv]
// ----------------------------------------------------------------------------
// uapq_pkg: shared types and constants of the unsorted array priority queue
// Command and status codes, the sequencer state type and the default size.
// ----------------------------------------------------------------------------
`default_nettype none

package uapq_pkg;

	// Default number of entries the queue can hold
	localparam int unsigned UAPQ_CAPACITY = 64;

	// Field widths fixed by the item format
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_FIND    = 2'd2,
		CMD_MODIFY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

endpackage : uapq_pkg

`default_nettype wire

[rtl/core/uapq_cmd_if.sv]
// ----------------------------------------------------------------------------
// uapq_cmd_if: command channel of the priority queue
// Valid/ready channel carrying one command item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface uapq_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] item_value;
	logic signed [31:0] item_key;

	modport source (output valid, output command, output item_value, output item_key,
		input ready);
	modport sink (input valid, input command, input item_value, input item_key,
		output ready);
endinterface : uapq_cmd_if

// ----------------------------------------------------------------------------
// uapq_rsp_if: result channel of the priority queue
// Valid/ready channel carrying one result item per handshake.
// ----------------------------------------------------------------------------
interface uapq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [31:0] out_key;
	logic [6:0]         entry_count;

	modport source (output valid, output status, output out_value, output out_key,
		output entry_count, input ready);
	modport sink (input valid, input status, input out_value, input out_key,
		input entry_count, output ready);
endinterface : uapq_rsp_if

`default_nettype wire

[rtl/core/unsorted_array_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_unit: max-priority queue on an unsorted table
// Value/key pairs in insertion order, held in one single-port-write memory.
// ----------------------------------------------------------------------------
// Each command item yields exactly one result item. The entries live in a
// memory with one write and one registered read port, and one compare unit
// walks it one entry per cycle. Insert needs no scan. Find-max and
// modify-key walk the N entries held (modify stops at the first value
// match). Extract-max walks all N entries and then shifts down the entries
// after the maximum by one place; the scan and the shift-down both go
// through the single memory read port.
// The command channel is ready only while the sequencer is idle; a finished
// result waits in the output register and does not hold off the next command.
`default_nettype none

module unsorted_array_priority_queue_unit #(
	parameter int unsigned CAPACITY = uapq_pkg::UAPQ_CAPACITY
) (
	input  wire       clk,
	input  wire       arst_n,
	uapq_cmd_if.sink  cmd,
	uapq_rsp_if.source rsp
);
	import uapq_pkg::*;

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned ENT_W = 2 * DATA_W;

	// Entry memory: value in the upper half, key in the lower half
	logic [ENT_W-1:0] mem [CAPACITY];

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [ENT_W-1:0]  rd_data_s1;

	cmd_t              cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] key_q;
	status_t           sts_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DATA_W-1:0] best_val_q;
	logic [DATA_W-1:0] best_key_q;

	logic              out_vld_q;
	status_t           out_sts_q;
	logic [DATA_W-1:0] out_val_q;
	logic [DATA_W-1:0] out_key_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// Control signals from the sequencer
	logic              accept;
	logic              is_full;
	logic              is_empty;
	logic              issue;
	logic              walk_done;
	logic              mod_hit;
	logic              better;
	logic              out_free;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [ENT_W-1:0]  mem_wdata;
	logic [DATA_W-1:0] rd_val;
	logic [DATA_W-1:0] rd_key;

	assign accept    = cmd.valid && cmd.ready;
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign walk_done = (idx_q >= count_q) && !rd_vld_s1;
	assign out_free  = !out_vld_q || rsp.ready;
	assign rd_val    = rd_data_s1[ENT_W-1:DATA_W];
	assign rd_key    = rd_data_s1[DATA_W-1:0];

	// Shared compare unit: value match for modify, signed key compare for max
	assign mod_hit = (state_q == ST_SCAN) && rd_vld_s1 && (cmd_q == CMD_MODIFY)
		&& (rd_val == val_q);
	assign better  = (state_q == ST_SCAN) && rd_vld_s1 && (cmd_q != CMD_MODIFY)
		&& ((rd_idx_s1 == '0) || ($signed(rd_key) > $signed(best_key_q)));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (cmd_q == CMD_INSERT || is_empty) state_d = ST_RESP;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (mod_hit) state_d = ST_RESP;
				else if (walk_done) state_d = (cmd_q == CMD_EXTRACT) ? ST_SHIFT : ST_RESP;
			end
			ST_SHIFT: begin
				if (walk_done) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: ready, read issue and memory write
	always_comb begin
		cmd.ready = 1'b0;
		issue     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = {val_q, key_q};
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
			end
			ST_DISPATCH: begin
				mem_we = (cmd_q == CMD_INSERT) && !is_full;
			end
			ST_SCAN: begin
				issue = (idx_q < count_q);
				if (mod_hit) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1;
					mem_wdata = {rd_val, key_q};
				end
			end
			ST_SHIFT: begin
				issue = (idx_q < count_q);
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - 1'b1;
					mem_wdata = rd_data_s1;
				end
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
		rd_idx_s1  <= idx_q[IDX_W-1:0];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			// Advance the walk pointer
			if (state_q == ST_DISPATCH) idx_q <= '0;
			else if (state_q == ST_SCAN && walk_done && cmd_q == CMD_EXTRACT)
				idx_q <= CNT_W'(best_idx_q) + 1'b1;
			else if (issue) idx_q <= idx_q + 1'b1;
			// Track the entry count
			if (state_q == ST_DISPATCH && cmd_q == CMD_INSERT && !is_full)
				count_q <= count_q + 1'b1;
			else if (state_q == ST_SHIFT && walk_done)
				count_q <= count_q - 1'b1;
			// Hold the result until taken
			if (state_q == ST_RESP && out_free) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	// Item payload, running maximum and result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd.command);
			val_q <= cmd.item_value;
			key_q <= cmd.item_key;
		end
		if (state_q == ST_DISPATCH) begin
			if (cmd_q == CMD_INSERT && is_full) sts_q <= STS_FULL;
			else if (is_empty) begin
				case (cmd_q) inside
					CMD_EXTRACT, CMD_FIND: sts_q <= STS_EMPTY;
					CMD_MODIFY:            sts_q <= STS_NOT_FOUND;
					default:               sts_q <= STS_OK;
				endcase
			end else sts_q <= STS_OK;
		end else if (state_q == ST_SCAN && cmd_q == CMD_MODIFY && walk_done && !mod_hit)
			sts_q <= STS_NOT_FOUND;
		if (better) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rd_val;
			best_key_q <= rd_key;
		end
		// Load the output register
		if (state_q == ST_RESP && out_free) begin
			out_sts_q <= sts_q;
			out_cnt_q <= COUNT_W'(count_q);
			if ((cmd_q == CMD_EXTRACT || cmd_q == CMD_FIND) && sts_q == STS_OK) begin
				out_val_q <= best_val_q;
				out_key_q <= best_key_q;
			end else begin
				out_val_q <= '0;
				out_key_q <= '0;
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_sts_q;
	assign rsp.out_value   = out_val_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.entry_count = out_cnt_q;

endmodule : unsorted_array_priority_queue_unit

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for unsorted_array_priority_queue_unit
// A short table of directed commands (empty reads, signed extremes, key ties,
// duplicate values) followed by random fill and drain sweeps under four
// pacing phases. A behavioral copy of the queue predicts every result item,
// and each result field is compared in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import uapq_pkg::*;

	localparam int unsigned DEPTH           = UAPQ_CAPACITY;
	localparam int unsigned ITEMS_PER_PHASE = 150;
	localparam int unsigned SETTLE_CYCLES   = 2 * DEPTH + 40;
	localparam int unsigned WATCHDOG_LIMIT  = 4000;

	typedef struct {
		logic signed [31:0] value;
		logic signed [31:0] key;
	} entry_t;

	typedef struct {
		status_t            status;
		logic signed [31:0] value;
		logic signed [31:0] key;
		logic [COUNT_W-1:0] count;
	} result_t;

	// one directed command; pinned rows carry their own expected result
	typedef struct {
		cmd_t        command;
		logic [31:0] value;
		logic [31:0] key;
		bit          pinned;
		status_t     status;
		logic [31:0] out_value;
		logic [31:0] out_key;
		int          count;
	} row_t;

	logic clk;
	logic arst_n;

	uapq_cmd_if cmd_ch ();
	uapq_rsp_if rsp_ch ();

	unsorted_array_priority_queue_unit #(
		.CAPACITY(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// shadow queue contents and the results still owed by the block
	entry_t      held[$];
	result_t     pending[$];
	bit          pin_next;
	result_t     pin_result;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned errors;
	int unsigned idle_cycles;
	int unsigned n_sent;
	int unsigned n_full;
	int unsigned n_empty;
	int unsigned n_missed;
	int unsigned peak;

	// apply one command to the shadow queue and return what the block must report
	function automatic result_t apply_command(cmd_t c, logic signed [31:0] v,
			logic signed [31:0] k);
		result_t r;
		int      best;
		int      i;
		r = '{STS_OK, 32'sd0, 32'sd0, '0};
		case (c) inside
			CMD_INSERT: begin
				if (held.size() >= DEPTH)
					r.status = STS_FULL;
				else
					held.push_back(entry_t'{v, k});
			end
			CMD_EXTRACT, CMD_FIND: begin
				if (held.size() == 0) begin
					r.status = STS_EMPTY;
				end else begin
					// earliest entry wins on equal keys
					best = 0;
					for (i = 1; i < held.size(); i++)
						if (held[i].key > held[best].key)
							best = i;
					r.value = held[best].value;
					r.key   = held[best].key;
					if (c == CMD_EXTRACT)
						held.delete(best);
				end
			end
			default: begin
				// only the first matching value gets the new key
				r.status = STS_NOT_FOUND;
				for (i = 0; i < held.size(); i++) begin
					if (held[i].value == v) begin
						held[i].key = k;
						r.status = STS_OK;
						break;
					end
				end
			end
		endcase
		r.count = COUNT_W'(held.size());
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	function automatic logic [31:0] pick_edge();
		case ($urandom_range(3))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			default: return 32'h0000_0000;
		endcase
	endfunction

	// small values repeat often so that modify finds duplicates
	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0, 1:    return 32'($urandom_range(15));
			2:       return $urandom;
			default: return pick_edge();
		endcase
	endfunction

	// keys near zero collide often so that ties are exercised
	function automatic logic [31:0] pick_key();
		case ($urandom_range(4))
			0, 1:    return 32'($urandom_range(8)) - 32'd4;
			2, 3:    return $urandom;
			default: return pick_edge();
		endcase
	endfunction

	// present one command item and hold it until the block takes it
	task automatic send_item(cmd_t c, logic [31:0] v, logic [31:0] k, bit pinned,
			result_t want);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= c;
		cmd_ch.item_value <= v;
		cmd_ch.item_key   <= k;
		pin_next          <= pinned;
		pin_result        <= want;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side: stall at random per cycle
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// predict on every accepted command, check every accepted result
	always @(posedge clk) begin
		result_t predicted;
		result_t want;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predicted = apply_command(cmd_t'(cmd_ch.command), cmd_ch.item_value,
					cmd_ch.item_key);
				pending.push_back(pin_next ? pin_result : predicted);
				n_sent++;
				if (held.size() > peak)
					peak = held.size();
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, actual %0d %h %h %0d",
						$time, rsp_ch.status, rsp_ch.out_value, rsp_ch.out_key,
						rsp_ch.entry_count);
				end else begin
					want = pending.pop_front();
					compare_field("status", 32'(want.status), 32'(rsp_ch.status));
					compare_field("out_value", want.value, rsp_ch.out_value);
					compare_field("out_key", want.key, rsp_ch.out_key);
					compare_field("entry_count", 32'(want.count), 32'(rsp_ch.entry_count));
					case (want.status)
						STS_FULL:      n_full++;
						STS_EMPTY:     n_empty++;
						STS_NOT_FOUND: n_missed++;
						default:       ;
					endcase
				end
			end
			idle_cycles <= ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				? 0 : idle_cycles + 1;
		end
	end

	// stop a hung run
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		row_t        plan[$];
		row_t        r;
		result_t     want;
		result_t     none;
		cmd_t        c;
		logic [31:0] v;
		logic [31:0] k;
		bit          filling;
		int unsigned pick;
		int unsigned n;
		int          phase;

		none = '{STS_OK, 32'sd0, 32'sd0, '0};
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = CMD_INSERT;
		cmd_ch.item_value = '0;
		cmd_ch.item_key   = '0;
		pin_next          = 1'b0;
		pin_result        = none;
		idle_pct          = 0;
		stall_pct         = 0;
		errors            = 0;
		idle_cycles       = 0;
		n_sent            = 0;
		n_full            = 0;
		n_empty           = 0;
		n_missed          = 0;
		peak              = 0;

		// directed commands: empty reads, signed extremes, ties, duplicate values
		plan.push_back(row_t'{CMD_FIND, 32'h0, 32'h0, 1'b1, STS_EMPTY, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b1, STS_EMPTY, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_MODIFY, 32'h0, 32'h1, 1'b1, STS_NOT_FOUND, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, STS_OK,
			32'h0, 32'h0, 1});
		plan.push_back(row_t'{CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, STS_OK,
			32'h0, 32'h0, 2});
		plan.push_back(row_t'{CMD_INSERT, 32'h0, 32'h7FFF_FFFF, 1'b1, STS_OK, 32'h0, 32'h0, 3});
		plan.push_back(row_t'{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STS_OK,
			32'h0, 32'h0, 4});
		plan.push_back(row_t'{CMD_FIND, 32'h0, 32'h0, 1'b1, STS_OK,
			32'h8000_0000, 32'h7FFF_FFFF, 4});
		plan.push_back(row_t'{CMD_INSERT, 32'd5, 32'd0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_INSERT, 32'd5, 32'd1, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_MODIFY, 32'd5, 32'h7FFF_FFFF, 1'b0, STS_OK,
			32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_MODIFY, 32'd12345, 32'd9, 1'b1, STS_NOT_FOUND,
			32'h0, 32'h0, 6});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b1, STS_OK,
			32'h8000_0000, 32'h7FFF_FFFF, 5});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_FIND, 32'h0, 32'h0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_MODIFY, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b0, STS_OK,
			32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b0, STS_OK, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_EXTRACT, 32'h0, 32'h0, 1'b1, STS_EMPTY, 32'h0, 32'h0, 0});
		plan.push_back(row_t'{CMD_MODIFY, 32'h7FFF_FFFF, 32'h0, 1'b1, STS_NOT_FOUND,
			32'h0, 32'h0, 0});

		// hold reset, then release on a falling edge
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table
		foreach (plan[i]) begin
			r = plan[i];
			want = '{r.status, r.out_value, r.out_key, COUNT_W'(r.count)};
			send_item(r.command, r.value, r.key, r.pinned, want);
		end

		// random sweeps: fill to full, drain to empty, under each pacing phase
		filling = 1'b1;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 50; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 50; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// hold off the sender until every owed result is back
				if (n == ITEMS_PER_PHASE / 2) begin
					cmd_ch.valid <= 1'b0;
					do
						@(negedge clk);
					while (pending.size() != 0);
				end
				if (filling && held.size() == DEPTH && $urandom_range(3) == 0)
					filling = 1'b0;
				else if (!filling && held.size() == 0 && $urandom_range(2) == 0)
					filling = 1'b1;
				pick = $urandom_range(99);
				if (filling)
					c = (pick < 70) ? CMD_INSERT : (pick < 80) ? CMD_EXTRACT :
						(pick < 90) ? CMD_FIND : CMD_MODIFY;
				else
					c = (pick < 15) ? CMD_INSERT : (pick < 70) ? CMD_EXTRACT :
						(pick < 85) ? CMD_FIND : CMD_MODIFY;
				// modify mostly targets a value that is held
				if (c == CMD_MODIFY && held.size() != 0 && $urandom_range(9) < 7)
					v = held[$urandom_range(held.size() - 1)].value;
				else
					v = pick_value();
				k = pick_key();
				send_item(c, v, k, 1'b0, none);
			end
		end

		// drop valid and let the last results drain
		cmd_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d commands (%0d directed) over four pacing phases, peak fill %0d of %0d.",
			n_sent, plan.size(), peak, DEPTH);
		$display("Saw %0d dropped inserts on a full queue, %0d empty reads, %0d unmatched modifies.",
			n_full, n_empty, n_missed);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule : testbench

`default_nettype wire

[sim.f]
rtl/core/uapq_pkg.sv
rtl/core/uapq_cmd_if.sv
rtl/core/unsorted_array_priority_queue_unit.sv
sim/testbench.sv
